@@ sv/agm_pkg.sv @@
// agm_pkg: shared constants, register codes and types of the axle gap matcher
// no dependencies; imported by every other file of the block but agm_checker
package agm_pkg;

	localparam int GAP_BITS_DEF = 16;
	localparam int FRAC_BITS    = 16;
	localparam int NUM_GAPS     = 5;
	localparam int CFG_IDX_BITS = 3;
	localparam int DIST_BITS    = 32;
	localparam int SQ_BITS      = 64;
	localparam int TERM_BITS    = SQ_BITS - FRAC_BITS;
	localparam int SUM_BITS     = TERM_BITS + 3;

	// reference register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LEFT_GAP        = 3'd0,
		REG_LEFT_BOGEY_GAP  = 3'd1,
		REG_MID_GAP         = 3'd2,
		REG_RIGHT_BOGEY_GAP = 3'd3,
		REG_RIGHT_GAP       = 3'd4
	} reg_idx_t;

	// plausibility flags of one transaction
	typedef struct packed {
		logic gaps_plausible;
		logic right_bogey_plausible;
		logic right_bogey_convincing;
	} flags_t;

endpackage

@@ sv/agm_if.sv @@
// agm_geom_if and agm_res_if: valid/ready channels of the axle gap matcher
// depends on agm_pkg for default widths
interface agm_geom_if #(parameter int GAP_BITS = agm_pkg::GAP_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [GAP_BITS-1:0] left_gap;
	logic                left_gap_valid;
	logic [GAP_BITS-1:0] left_bogey_gap;
	logic [GAP_BITS-1:0] mid_gap;
	logic [GAP_BITS-1:0] right_bogey_gap;
	logic [GAP_BITS-1:0] right_gap;
	logic                right_gap_valid;

	modport source(output valid, left_gap, left_gap_valid, left_bogey_gap, mid_gap,
		right_bogey_gap, right_gap, right_gap_valid, input ready);
	modport sink(input valid, left_gap, left_gap_valid, left_bogey_gap, mid_gap,
		right_bogey_gap, right_gap, right_gap_valid, output ready);
endinterface

interface agm_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;
	logic        gaps_plausible;
	logic        right_bogey_plausible;
	logic        right_bogey_convincing;

	modport source(output valid, distance, gaps_plausible, right_bogey_plausible,
		right_bogey_convincing, input ready);
	modport sink(input valid, distance, gaps_plausible, right_bogey_plausible,
		right_bogey_convincing, output ready);
endinterface

@@ sv/axle_gap_geometry_matcher_unit.sv @@
// axle_gap_geometry_matcher_unit: top level of the axle gap geometry matcher
// depends on agm_pkg, agm_if, agm_div, agm_score and agm_checks
//
// Usage:
//   geometry carries one measured car geometry per transaction, result one
//   distance plus three plausibility flags per transaction, both valid/ready.
//   The reference geometry sits in five registers written through cfg_we,
//   cfg_index and cfg_data; indexes beyond the last register are ignored.
//   Write them only while no transaction is in flight.
//   The pipeline is one input stage, GAP_BITS + 16 stages of the five
//   parallel bit-per-stage dividers, then square, sum and scale stages.
//   Throughput is one transaction per cycle while the receiver takes results.
//   The whole pipeline advances together; when the receiver stalls with a
//   result waiting, every stage holds and geometry.ready drops, and an
//   empty output slot keeps the pipeline moving. Reset clears all valid
//   bits and the reference registers to zero.
module axle_gap_geometry_matcher_unit #(
	parameter int GAP_BITS = agm_pkg::GAP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	agm_geom_if.sink                          geometry,
	agm_res_if.source                         result,
	input  logic                              cfg_we,
	input  logic [agm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [GAP_BITS-1:0]               cfg_data
);
	import agm_pkg::*;

	localparam int Q = GAP_BITS + FRAC_BITS;
	localparam int L = Q + 4;

	logic [GAP_BITS-1:0] ref_left_gap_q, ref_left_bogey_gap_q, ref_mid_gap_q;
	logic [GAP_BITS-1:0] ref_right_bogey_gap_q, ref_right_gap_q;

	// reference registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_left_gap_q        <= '0;
			ref_left_bogey_gap_q  <= '0;
			ref_mid_gap_q         <= '0;
			ref_right_bogey_gap_q <= '0;
			ref_right_gap_q       <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_GAP:        ref_left_gap_q        <= cfg_data;
				REG_LEFT_BOGEY_GAP:  ref_left_bogey_gap_q  <= cfg_data;
				REG_MID_GAP:         ref_mid_gap_q         <= cfg_data;
				REG_RIGHT_BOGEY_GAP: ref_right_bogey_gap_q <= cfg_data;
				REG_RIGHT_GAP:       ref_right_gap_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// global advance: move when the output slot is empty or being taken
	logic         en;
	logic [L-1:0] vld_q;
	assign en             = !vld_q[L-1] || result.ready;
	assign geometry.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], geometry.valid};
		end
	end

	// plausibility flags, delayed alongside the distance
	flags_t flg_c;
	flags_t flg_q [L];

	agm_checks #(.GAP_BITS(GAP_BITS)) u_checks (
		.left_gap            (geometry.left_gap),
		.left_gap_valid      (geometry.left_gap_valid),
		.left_bogey_gap      (geometry.left_bogey_gap),
		.mid_gap             (geometry.mid_gap),
		.right_bogey_gap     (geometry.right_bogey_gap),
		.right_gap           (geometry.right_gap),
		.right_gap_valid     (geometry.right_gap_valid),
		.ref_left_gap        (ref_left_gap_q),
		.ref_left_bogey_gap  (ref_left_bogey_gap_q),
		.ref_right_bogey_gap (ref_right_bogey_gap_q),
		.ref_right_gap       (ref_right_gap_q),
		.flags               (flg_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flg_q[0] <= flg_c;
			for (int k = 1; k < L; k++) begin
				flg_q[k] <= flg_q[k-1];
			end
		end
	end

	// input stage: order each measured/reference pair
	logic [GAP_BITS-1:0] meas [NUM_GAPS];
	logic [GAP_BITS-1:0] refv [NUM_GAPS];
	logic [GAP_BITS-1:0] big_s1 [NUM_GAPS];
	logic [GAP_BITS-1:0] lit_s1 [NUM_GAPS];
	logic                act_s1 [NUM_GAPS];
	logic [Q-1:0]        ratio  [NUM_GAPS];
	logic                act_d  [NUM_GAPS];

	assign meas[0] = geometry.left_gap;
	assign meas[1] = geometry.left_bogey_gap;
	assign meas[2] = geometry.mid_gap;
	assign meas[3] = geometry.right_bogey_gap;
	assign meas[4] = geometry.right_gap;
	assign refv[0] = ref_left_gap_q;
	assign refv[1] = ref_left_bogey_gap_q;
	assign refv[2] = ref_mid_gap_q;
	assign refv[3] = ref_right_bogey_gap_q;
	assign refv[4] = ref_right_gap_q;

	for (genvar i = 0; i < NUM_GAPS; i++) begin : g_lane
		logic [GAP_BITS-1:0] big, lit;
		logic                act;

		assign big = (meas[i] > refv[i]) ? meas[i] : refv[i];
		assign lit = (meas[i] > refv[i]) ? refv[i] : meas[i];
		// term counts only when both exist and ratio is above 11/10
		assign act = (meas[i] != '0) && (refv[i] != '0)
			&& ((GAP_BITS+4)'(big) * (GAP_BITS+4)'(10) > (GAP_BITS+4)'(lit) * (GAP_BITS+4)'(11));

		always_ff @(posedge clk) begin
			if (en) begin
				big_s1[i] <= big;
				lit_s1[i] <= lit;
				act_s1[i] <= act;
			end
		end

		agm_div #(.GAP_BITS(GAP_BITS)) u_div (
			.clk     (clk),
			.en      (en),
			.dvd     (big_s1[i]),
			.dvs     (lit_s1[i]),
			.act_in  (act_s1[i]),
			.ratio   (ratio[i]),
			.act_out (act_d[i])
		);
	end

	logic [DIST_BITS-1:0] distance;

	agm_score #(.GAP_BITS(GAP_BITS)) u_score (
		.clk      (clk),
		.en       (en),
		.ratio    (ratio),
		.act      (act_d),
		.distance (distance)
	);

	// output channel
	assign result.valid                  = vld_q[L-1];
	assign result.distance               = distance;
	assign result.gaps_plausible         = flg_q[L-1].gaps_plausible;
	assign result.right_bogey_plausible  = flg_q[L-1].right_bogey_plausible;
	assign result.right_bogey_convincing = flg_q[L-1].right_bogey_convincing;

endmodule

@@ sv/agm_div.sv @@
// agm_div: pipelined restoring divider, one quotient bit per stage
// computes (dvd << FRAC_BITS) / dvs; depends on agm_pkg
module agm_div #(
	parameter int GAP_BITS = agm_pkg::GAP_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [GAP_BITS-1:0]                    dvd,
	input  logic [GAP_BITS-1:0]                    dvs,
	input  logic                                   act_in,
	output logic [GAP_BITS+agm_pkg::FRAC_BITS-1:0] ratio,
	output logic                                   act_out
);
	import agm_pkg::*;

	localparam int Q = GAP_BITS + FRAC_BITS;

	logic [GAP_BITS-1:0] rem_s [1:Q];
	logic [Q-1:0]        num_s [1:Q];
	logic [Q-1:0]        quo_s [1:Q];
	logic [GAP_BITS-1:0] dvs_s [1:Q];
	logic                act_s [1:Q];

	// one trial subtraction per stage
	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic [GAP_BITS-1:0] rem_i, dvs_i;
		logic [Q-1:0]        num_i, quo_i;
		logic                act_i;
		logic [GAP_BITS:0]   trial;
		logic                ge;

		// stage zero feeds straight from the inputs
		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign num_i = {dvd, {FRAC_BITS{1'b0}}};
			assign quo_i = '0;
			assign dvs_i = dvs;
			assign act_i = act_in;
		end else begin : g_next
			assign rem_i = rem_s[k];
			assign num_i = num_s[k];
			assign quo_i = quo_s[k];
			assign dvs_i = dvs_s[k];
			assign act_i = act_s[k];
		end

		assign trial = {rem_i, num_i[Q-1]};
		assign ge    = trial >= {1'b0, dvs_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? GAP_BITS'(trial - {1'b0, dvs_i}) : trial[GAP_BITS-1:0];
				num_s[k+1] <= {num_i[Q-2:0], 1'b0};
				quo_s[k+1] <= {quo_i[Q-2:0], ge};
				dvs_s[k+1] <= dvs_i;
				act_s[k+1] <= act_i;
			end
		end
	end

	assign ratio   = quo_s[Q];
	assign act_out = act_s[Q];

endmodule

@@ sv/agm_score.sv @@
// agm_score: squares the ratio excess per gap, sums and scales to the distance
// three register stages; depends on agm_pkg
module agm_score #(
	parameter int GAP_BITS = agm_pkg::GAP_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [GAP_BITS+agm_pkg::FRAC_BITS-1:0] ratio [agm_pkg::NUM_GAPS],
	input  logic                                   act   [agm_pkg::NUM_GAPS],
	output logic [agm_pkg::DIST_BITS-1:0]          distance
);
	import agm_pkg::*;

	localparam int SCL_BITS = SUM_BITS + 7;

	logic [SQ_BITS-1:0]   sq_s1 [NUM_GAPS];
	logic [SUM_BITS-1:0]  sum_s2;
	logic [DIST_BITS-1:0] dist_s3;

	// excess over one, clamped to 32 bits, then squared
	for (genvar i = 0; i < NUM_GAPS; i++) begin : g_lane
		logic [SQ_BITS-1:0] d64;
		logic [31:0]        dcl;

		assign d64 = SQ_BITS'(ratio[i]) - (SQ_BITS'(1) << FRAC_BITS);
		assign dcl = !act[i] ? 32'd0 :
			(d64 > SQ_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : d64[31:0];

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s1[i] <= SQ_BITS'(dcl) * SQ_BITS'(dcl);
			end
		end
	end

	// sum of the five terms
	logic [SUM_BITS-1:0] sum_c;
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NUM_GAPS; i++) begin
			sum_c = sum_c + SUM_BITS'(sq_s1[i][SQ_BITS-1:FRAC_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_c;
		end
	end

	// times 100 over 256, saturating
	logic [SCL_BITS-1:0] scaled;
	logic [SCL_BITS-9:0] shr;
	assign scaled = (SCL_BITS'(sum_s2) << 6) + (SCL_BITS'(sum_s2) << 5)
		+ (SCL_BITS'(sum_s2) << 2);
	assign shr = scaled[SCL_BITS-1:8];

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s3 <= (shr > (SCL_BITS-8)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : shr[31:0];
		end
	end

	assign distance = dist_s3;

endmodule

@@ sv/agm_checks.sv @@
// agm_checks: rational-factor plausibility checks on one measured geometry
// combinational; depends on agm_pkg for flags_t
module agm_checks #(
	parameter int GAP_BITS = agm_pkg::GAP_BITS_DEF
) (
	input  logic [GAP_BITS-1:0] left_gap,
	input  logic                left_gap_valid,
	input  logic [GAP_BITS-1:0] left_bogey_gap,
	input  logic [GAP_BITS-1:0] mid_gap,
	input  logic [GAP_BITS-1:0] right_bogey_gap,
	input  logic [GAP_BITS-1:0] right_gap,
	input  logic                right_gap_valid,
	input  logic [GAP_BITS-1:0] ref_left_gap,
	input  logic [GAP_BITS-1:0] ref_left_bogey_gap,
	input  logic [GAP_BITS-1:0] ref_right_bogey_gap,
	input  logic [GAP_BITS-1:0] ref_right_gap,
	output agm_pkg::flags_t     flags
);
	import agm_pkg::*;

	localparam int PW = GAP_BITS + 7;

	// fails when a*q > p*r or a*p < q*r
	function automatic logic two_sided(input logic [GAP_BITS-1:0] a, input logic [GAP_BITS-1:0] r,
		input logic [6:0] p, input logic [6:0] q);
		logic [PW-1:0] aq, pr, ap, qr;
		aq = PW'(a) * PW'(q);
		pr = PW'(p) * PW'(r);
		ap = PW'(a) * PW'(p);
		qr = PW'(q) * PW'(r);
		return !((aq > pr) || (ap < qr));
	endfunction

	// fails when a*p < q*r
	function automatic logic too_short_ok(input logic [GAP_BITS-1:0] a,
		input logic [GAP_BITS-1:0] r, input logic [6:0] p, input logic [6:0] q);
		logic [PW-1:0] ap, qr;
		ap = PW'(a) * PW'(p);
		qr = PW'(q) * PW'(r);
		return !(ap < qr);
	endfunction

	logic ok_l, ok_r, ok_b, ok_m;

	always_comb begin
		ok_l = !left_gap_valid || (two_sided(left_gap, ref_left_gap, 7'd2, 7'd1)
			&& too_short_ok(left_gap, ref_left_bogey_gap, 7'd2, 7'd1));
		ok_r = !right_gap_valid || (two_sided(right_gap, ref_right_gap, 7'd2, 7'd1)
			&& too_short_ok(right_gap, ref_right_bogey_gap, 7'd2, 7'd1));
		ok_b = two_sided(left_bogey_gap, right_bogey_gap, 7'd6, 7'd5);
		// mid gap against whichever bogey exists, left first
		if (left_bogey_gap != '0) begin
			ok_m = too_short_ok(mid_gap, left_bogey_gap, 7'd67, 7'd100);
		end else if (right_bogey_gap != '0) begin
			ok_m = too_short_ok(mid_gap, right_bogey_gap, 7'd67, 7'd100);
		end else begin
			ok_m = 1'b0;
		end
		flags.gaps_plausible         = ok_l && ok_r && ok_b && ok_m;
		flags.right_bogey_plausible  = two_sided(right_bogey_gap, ref_right_bogey_gap, 7'd3, 7'd2);
		flags.right_bogey_convincing = two_sided(right_bogey_gap, ref_right_bogey_gap,
			7'd11, 7'd10);
	end

endmodule

@@ sv/agm_checker.sv @@
// agm_checker: port-level assertions for the axle gap geometry matcher
// bound to axle_gap_geometry_matcher_unit; no package dependency
module agm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] distance,
	input logic        right_bogey_plausible,
	input logic        right_bogey_convincing
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its distance
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance))
		else $error("distance changed while stalled");

	// input side only blocks when the output slot is full and stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	// the 11/10 band lies inside the 3/2 band
	a_bands: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && right_bogey_convincing |-> right_bogey_plausible)
		else $error("convincing without plausible");

endmodule

bind axle_gap_geometry_matcher_unit agm_checker u_agm_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.in_ready               (geometry.ready),
	.out_valid              (result.valid),
	.out_ready              (result.ready),
	.distance               (result.distance),
	.right_bogey_plausible  (result.right_bogey_plausible),
	.right_bogey_convincing (result.right_bogey_convincing)
);

@@ tb/tb_axle_gap_geometry_matcher_unit.sv @@
// tb_axle_gap_geometry_matcher_unit: self-checking testbench of the axle gap matcher
// depends on agm_pkg, agm_if and axle_gap_geometry_matcher_unit
`timescale 1ns / 1ps
module tb_axle_gap_geometry_matcher_unit;
	import agm_pkg::*;

	localparam int GB = GAP_BITS_DEF;
	localparam int LATENCY = GB + 20;

	typedef struct packed {
		logic [GB-1:0] lg;
		logic          lv;
		logic [GB-1:0] lb;
		logic [GB-1:0] mg;
		logic [GB-1:0] rb;
		logic [GB-1:0] rg;
		logic          rv;
	} geom_t;

	typedef struct packed {
		logic [31:0] distance;
		logic        plausible;
		logic        rb_plausible;
		logic        rb_convincing;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [GB-1:0] cfg_data = '0;

	agm_geom_if #(.GAP_BITS(GB)) geometry();
	agm_res_if result();

	axle_gap_geometry_matcher_unit #(.GAP_BITS(GB)) DUT (
		.clk(clk), .arst_n(arst_n), .geometry(geometry.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// reference geometry as the predictor sees it
	logic [GB-1:0] ref_gap [NUM_GAPS];
	match_t expected_matches[$];
	int mismatches = 0;
	int stall_hold = 0;
	int burst_left = 0;
	bit stall_mode = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// squared ratio deviation of one gap pair, Q32.16
	function automatic logic [63:0] pair_term(logic [63:0] m, logic [63:0] r);
		logic [63:0] big, sml, d;
		if (m == 0 || r == 0) return 64'd0;
		big = (m > r) ? m : r;
		sml = (m > r) ? r : m;
		if (10 * big <= 11 * sml) return 64'd0;
		d = (big << 16) / sml - 64'd65536;
		if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
		return (d * d) >> 16;
	endfunction

	function automatic bit in_band(logic [63:0] a, logic [63:0] r, int p, int q);
		return !(a * q > p * r || a * p < q * r);
	endfunction

	function automatic bit not_short(logic [63:0] a, logic [63:0] r, int p, int q);
		return !(a * p < q * r);
	endfunction

	function automatic match_t predict_match(geom_t g);
		match_t res;
		logic [67:0] sum;
		logic [75:0] scaled_sum;
		bit ok;
		ok = 1;
		sum = pair_term(g.lg, ref_gap[REG_LEFT_GAP]) + pair_term(g.lb, ref_gap[REG_LEFT_BOGEY_GAP])
			+ pair_term(g.mg, ref_gap[REG_MID_GAP])
			+ pair_term(g.rb, ref_gap[REG_RIGHT_BOGEY_GAP])
			+ pair_term(g.rg, ref_gap[REG_RIGHT_GAP]);
		scaled_sum = (76'(sum) * 100) >> 8;
		res.distance = (scaled_sum > 76'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled_sum[31:0];
		if (g.lv && (!in_band(g.lg, ref_gap[REG_LEFT_GAP], 2, 1)
				|| !not_short(g.lg, ref_gap[REG_LEFT_BOGEY_GAP], 2, 1)))
			ok = 0;
		if (ok && g.rv && (!in_band(g.rg, ref_gap[REG_RIGHT_GAP], 2, 1)
				|| !not_short(g.rg, ref_gap[REG_RIGHT_BOGEY_GAP], 2, 1)))
			ok = 0;
		if (ok && !in_band(g.lb, g.rb, 6, 5)) ok = 0;
		if (ok) begin
			if (g.lb > 0) ok = not_short(g.mg, g.lb, 67, 100);
			else if (g.rb > 0) ok = not_short(g.mg, g.rb, 67, 100);
			else ok = 0;
		end
		res.plausible = ok;
		res.rb_plausible = in_band(g.rb, ref_gap[REG_RIGHT_BOGEY_GAP], 3, 2);
		res.rb_convincing = in_band(g.rb, ref_gap[REG_RIGHT_BOGEY_GAP], 11, 10);
		return res;
	endfunction

	// send one geometry, with bursty gaps in front; valid stays up within a burst
	task automatic send_geometry(geom_t g);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				geometry.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		geometry.valid <= 1'b1;
		{geometry.left_gap, geometry.left_gap_valid, geometry.left_bogey_gap, geometry.mid_gap,
			geometry.right_bogey_gap, geometry.right_gap, geometry.right_gap_valid} <= g;
		do @(posedge clk); while (!geometry.ready);
		expected_matches.push_back(predict_match(g));
		@(negedge clk);
	endtask

	task automatic write_ref(reg_idx_t idx, logic [GB-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		ref_gap[idx] = v;
		@(negedge clk);
	endtask

	task automatic write_bad_index();
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_BITS'($urandom_range(NUM_GAPS, 7));
		cfg_data <= GB'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait until everything has come out
	task automatic drain();
		geometry.valid <= 1'b0;
		while (expected_matches.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [GB-1:0] rand_gap();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return GB'($urandom_range(1, 4));
			default: return GB'($urandom);
		endcase
	endfunction

	function automatic logic [GB-1:0] near(logic [GB-1:0] r);
		int v;
		v = int'(r) + $urandom_range(0, 2 * (int'(r) / 4 + 2)) - (int'(r) / 4 + 2);
		if (v < 0) v = 0;
		if (v > (1 << GB) - 1) v = (1 << GB) - 1;
		return GB'(v);
	endfunction

	// realistic car: measurements close to the reference
	function automatic geom_t car_like();
		geom_t g;
		g.lg = near(ref_gap[REG_LEFT_GAP]);
		g.lb = near(ref_gap[REG_LEFT_BOGEY_GAP]);
		g.mg = near(ref_gap[REG_MID_GAP]);
		g.rb = near(ref_gap[REG_RIGHT_BOGEY_GAP]);
		g.rg = near(ref_gap[REG_RIGHT_GAP]);
		g.lv = $urandom_range(0, 1);
		g.rv = $urandom_range(0, 1);
		return g;
	endfunction

	task automatic set_refs(logic [GB-1:0] a, b, c, d, e);
		write_ref(REG_LEFT_GAP, a);
		write_ref(REG_LEFT_BOGEY_GAP, b);
		write_ref(REG_MID_GAP, c);
		write_ref(REG_RIGHT_BOGEY_GAP, d);
		write_ref(REG_RIGHT_GAP, e);
	endtask

	// extremes, zero bogeys, clamped ratio, reset-state references
	task automatic test_directed();
		send_geometry({16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
		send_geometry({16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
		drain();
		set_refs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		write_bad_index();
		send_geometry({16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
		send_geometry({16'd1, 1'b1, 16'd0, 16'd5, 16'd0, 16'd1, 1'b1});
		drain();
		set_refs(16'd500, 16'd250, 16'd1200, 16'd250, 16'd500);
		send_geometry({16'd500, 1'b1, 16'd250, 16'd1200, 16'd250, 16'd500, 1'b1});
		send_geometry({16'd550, 1'b1, 16'd250, 16'd167, 16'd250, 16'd450, 1'b1});
		send_geometry({16'd500, 1'b0, 16'd0, 16'd168, 16'd250, 16'd500, 1'b0});
		send_geometry({16'd500, 1'b1, 16'd300, 16'd1200, 16'd250, 16'd1001, 1'b1});
		send_geometry({16'd499, 1'b1, 16'd250, 16'd1200, 16'd375, 16'd500, 1'b1});
		send_geometry({16'd500, 1'b1, 16'd250, 16'd1200, 16'd376, 16'd500, 1'b1});
		send_geometry({16'd500, 1'b1, 16'd250, 16'd1200, 16'd275, 16'd500, 1'b1});
		send_geometry({16'd500, 1'b1, 16'd0, 16'd1200, 16'd0, 16'd500, 1'b1});
		drain();
		set_refs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_geometry({16'd1, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1});
		send_geometry({16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
		drain();
	endtask

	task automatic test_random(int n);
		geom_t g;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) g = car_like();
			else begin
				g = geom_t'({$urandom, $urandom, $urandom});
				g.lg = rand_gap(); g.mg = rand_gap(); g.rb = rand_gap();
			end
			send_geometry(g);
		end
	endtask

	// several reference settings, random transactions against each
	task automatic test_settings();
		for (int s = 0; s < 8; s++) begin
			drain();
			set_refs(rand_gap(), GB'($urandom_range(100, 4000)), rand_gap(),
				GB'($urandom_range(100, 4000)), rand_gap());
			if (s == 3) begin
				// long hold-off while transactions keep coming
				stall_hold = 300;
				test_random(80);
			end else
				test_random(120);
		end
	endtask

	// receiver: stall pattern plus a long counted hold-off
	always @(negedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			result.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
			result.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		match_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got = {result.distance, result.gaps_plausible, result.right_bogey_plausible,
				result.right_bogey_convincing};
			if (expected_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %h", got);
			end else begin
				want = expected_matches.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: dist exp %0d got %0d, flags exp %b%b%b got %b%b%b",
							want.distance, got.distance, want.plausible, want.rb_plausible,
							want.rb_convincing, got.plausible, got.rb_plausible,
							got.rb_convincing);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_GAPS; i++) ref_gap[i] = '0;
		geometry.valid = 1'b0;
		{geometry.left_gap, geometry.left_gap_valid, geometry.left_bogey_gap, geometry.mid_gap,
			geometry.right_bogey_gap, geometry.right_gap, geometry.right_gap_valid} = '0;
		result.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_settings();
		drain();
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
